### hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] ReplChar     = 16'hFFFD;
  localparam logic [20:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [20:0] SurrFirst    = 21'h00D800;
  localparam logic [20:0] SurrLast     = 21'h00DFFF;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [5:0]  HiSurrTag    = 6'b110110;
  localparam logic [5:0]  LoSurrTag    = 6'b110111;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_last;
  } out_item_t;

  // Sequence accumulator.
  typedef struct packed {
    logic [20:0] partial_code;
    logic [1:0]  bytes_expected;
  } seq_state_t;

  // Results caused by one input byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]           count;
    out_item_t [1:0]      items;
  } dec_result_t;

endpackage

`default_nettype wire

### hw/rtl/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channel interfaces
// Byte input channel and code unit output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       stream_end;

  modport source (output valid, output byte_value, output stream_end, input ready);
  modport sink   (input valid, input byte_value, input stream_end, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        text_last;

  modport source (output valid, output code_unit, output run_last, output text_last,
                  input ready);
  modport sink   (input valid, input code_unit, input run_last, input text_last,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, replacing bad input.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  handshake
//  byte_i   in   byte_value[7:0], stream_end              valid/ready
//  unit_o   out  code_unit[15:0], run_last, text_last     valid/ready
//
//  A byte is registered on accept and decoded in the next cycle; its results
//  land in a two-entry result register, which drives unit_o. One byte per
//  cycle is sustained while unit_o stays ready and each byte yields at most
//  one code unit; a byte that yields two (surrogate pair, or a replacement
//  plus a unit) holds the pipe while the output port drains the first of them.
//  Stalls on unit_o back up into byte_i.ready.
//  Reset clears the sequence state and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8u16_byte_if.sink   byte_i,
  u8u16_unit_if.source unit_o
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       end_q;

  // Open sequence accumulator
  u8u16_pkg::seq_state_t seq_q, seq_d;

  u8u16_pkg::dec_result_t dec_res;
  logic                   buf_free;
  logic                   advance;

  // The held byte moves on once the result register can take its results.
  assign advance      = in_vld_q && buf_free;
  assign byte_i.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (byte_i.valid && byte_i.ready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.byte_value;
      end_q  <= byte_i.stream_end;
    end
  end

  u8u16_decode u_decode (
    .byte_value_i (byte_q),
    .stream_end_i (end_q),
    .state_i      (seq_q),
    .state_o      (seq_d),
    .result_o     (dec_res)
  );

  // Sequence state only moves together with the byte it belongs to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (advance) begin
      seq_q <= seq_d;
    end
  end

  u8u16_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (dec_res),
    .free_o   (buf_free),
    .unit_o   (unit_o)
  );

endmodule

`default_nettype wire

### hw/rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Combinational decode of one byte against the open sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode (
  input  logic [7:0]             byte_value_i,
  input  logic                   stream_end_i,
  input  u8u16_pkg::seq_state_t  state_i,
  output u8u16_pkg::seq_state_t  state_o,
  output u8u16_pkg::dec_result_t result_o
);

  logic        seq_open;
  logic        is_cont;
  logic        cont_hit;
  logic        completes;
  logic [20:0] shifted;
  logic        cp_bad;
  logic [20:0] cp;
  logic [19:0] supp_off;
  logic [1:0]  idx;
  logic [1:0][15:0] units;
  u8u16_pkg::seq_state_t st;

  assign seq_open = (state_i.bytes_expected != 2'd0);
  assign is_cont  = (byte_value_i[7:6] == 2'b10);
  assign cont_hit = seq_open && is_cont;
  assign shifted  = {state_i.partial_code[14:0], byte_value_i[5:0]};
  assign completes = cont_hit && (state_i.bytes_expected == 2'd1);

  // Out-of-range and surrogate values collapse to the replacement char.
  assign cp_bad = (shifted > u8u16_pkg::MaxCodePoint) ||
                  ((shifted >= u8u16_pkg::SurrFirst) && (shifted <= u8u16_pkg::SurrLast));
  assign cp       = cp_bad ? {5'd0, u8u16_pkg::ReplChar} : shifted;
  assign supp_off = 20'(cp - u8u16_pkg::SuppBase);

  always_comb begin
    st    = state_i;
    idx   = 2'd0;
    units = '0;

    if (cont_hit) begin
      st.partial_code   = shifted;
      st.bytes_expected = state_i.bytes_expected - 2'd1;
      if (completes) begin
        st.partial_code = '0;
        if (cp[20:16] == 5'd0) begin
          units[0] = cp[15:0];
          idx      = 2'd1;
        end else begin
          units[0] = {u8u16_pkg::HiSurrTag, supp_off[19:10]};
          units[1] = {u8u16_pkg::LoSurrTag, supp_off[9:0]};
          idx      = 2'd2;
        end
      end
    end else begin
      // interrupted sequence: replace it, then take the byte as a lead
      if (seq_open) begin
        units[0] = u8u16_pkg::ReplChar;
        idx      = 2'd1;
        st       = '0;
      end
      if (!byte_value_i[7]) begin
        units[idx[0]] = {8'd0, byte_value_i};
        idx           = idx + 2'd1;
      end else if (byte_value_i[7:5] == 3'b110) begin
        st.partial_code   = {16'd0, byte_value_i[4:0]};
        st.bytes_expected = 2'd1;
      end else if (byte_value_i[7:4] == 4'b1110) begin
        st.partial_code   = {17'd0, byte_value_i[3:0]};
        st.bytes_expected = 2'd2;
      end else if (byte_value_i[7:3] == 5'b11110) begin
        st.partial_code   = {18'd0, byte_value_i[2:0]};
        st.bytes_expected = 2'd3;
      end else begin
        units[idx[0]] = u8u16_pkg::ReplChar;
        idx           = idx + 2'd1;
      end
    end

    // truncated tail
    if (stream_end_i) begin
      if (st.bytes_expected != 2'd0) begin
        units[idx[0]] = u8u16_pkg::ReplChar;
        idx           = idx + 2'd1;
      end
      st = '0;
    end
  end

  always_comb begin
    result_o.count = idx;
    for (int i = 0; i < 2; i++) begin
      result_o.items[i].code_unit = units[i];
      result_o.items[i].run_last  = (idx == 2'(i + 1));
      result_o.items[i].text_last = (idx == 2'(i + 1)) && stream_end_i;
    end
  end

  assign state_o = st;

endmodule

`default_nettype wire

### hw/rtl/u8u16_outbuf.sv
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Two-entry result register; drains one code unit per cycle while unit_o is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outbuf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  u8u16_pkg::dec_result_t  result_i,
  output logic                    free_o,
  u8u16_unit_if.source            unit_o
);

  logic [1:0]                 cnt_q, cnt_d;
  u8u16_pkg::out_item_t [1:0] slot_q, slot_d;
  logic                       pop;

  assign pop    = (cnt_q != 2'd0) && unit_o.ready;
  // Room for a new item's results once the last held one leaves.
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && unit_o.ready);

  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d  = result_i.count;
      slot_d = result_i.items;
    end else if (pop) begin
      cnt_d     = cnt_q - 2'd1;
      slot_d[0] = slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign unit_o.valid     = (cnt_q != 2'd0);
  assign unit_o.code_unit = slot_q[0].code_unit;
  assign unit_o.run_last  = slot_q[0].run_last;
  assign unit_o.text_last = slot_q[0].text_last;

endmodule

`default_nettype wire

### hw/rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks on the transcoder output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [15:0] code_unit_i,
  input logic        run_last_i,
  input logic        text_last_i
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(code_unit_i) && $stable(run_last_i)
                            && $stable(text_last_i))
    else $error("output item changed under stall");

  // high surrogate is followed at once by its low half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && (code_unit_i[15:10] == u8u16_pkg::HiSurrTag)
      |=> valid_i && (code_unit_i[15:10] == u8u16_pkg::LoSurrTag))
    else $error("surrogate pair split");

  // a high surrogate never ends a byte's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (code_unit_i[15:10] == u8u16_pkg::HiSurrTag) |-> !run_last_i)
    else $error("high surrogate marked last");

  // end of text is always the end of a byte's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && text_last_i |-> run_last_i)
    else $error("text_last without run_last");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (unit_o.valid),
  .ready_i     (unit_o.ready),
  .code_unit_i (unit_o.code_unit),
  .run_last_i  (unit_o.run_last),
  .text_last_i (unit_o.text_last)
);

`default_nettype wire
